### rtl/rbs_pkg.sv
// Shared constants, types and a helper function of the retry backoff scheduler.
package rbs_pkg;

  // Number of channel records kept by the scheduler.
  localparam int CHANNELS = 16;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths of the item and result transfers.
  localparam int OPCODE_W = 3;
  localparam int CHAN_W   = 4;
  localparam int RND_W    = 32;
  localparam int ACTION_W = 4;
  localparam int DELAY_W  = 17;
  localparam int ATT_W    = 16;

  // Configuration port.
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTEMPTS = 2'd3;

  // Register reset values.
  localparam logic [CFG_W-1:0] RESET_INITIAL = 16'd8;
  localparam logic [CFG_W-1:0] RESET_MAX     = CFG_W'(8 * 60);

  // Backoff arithmetic.
  localparam int BASE_W     = 16;
  localparam int SHIFT_CAP  = 20;
  localparam int SHIFT_W    = 5;
  localparam int SHL_W      = BASE_W + SHIFT_CAP;
  localparam int JITTER_DIV = 4;
  localparam int SPAN_W     = 15;
  localparam int RND_LO_W   = 16;
  localparam int PROD_W     = RND_LO_W + SPAN_W;
  localparam logic [ATT_W-1:0] ATT_MAX = '1;

  // Limit used for the channel range check, one bit wider than the field.
  localparam logic [CHAN_W:0] CHAN_LIMIT = (CHAN_W + 1)'(CHANNELS);

  // Opcodes of the input item.
  localparam logic [OPCODE_W-1:0] OP_FAIL   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_CANCEL = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_EXPIRE = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_NETUP  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_QUERY  = 3'd4;

  // Result actions.
  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE      = 4'd0,
    ACT_IGNORED   = 4'd1,
    ACT_RESET     = 4'd2,
    ACT_GAVE_UP   = 4'd3,
    ACT_SCHEDULED = 4'd4,
    ACT_DROPPED   = 4'd5,
    ACT_PARKED    = 4'd6,
    ACT_CONNECT   = 4'd7,
    ACT_QUERY     = 4'd8
  } action_t;

  // Command classes produced by the front end.
  typedef enum logic [2:0] {
    K_FAIL    = 3'd0,
    K_RESET   = 3'd1,
    K_EXPIRE  = 3'd2,
    K_NETUP   = 3'd3,
    K_QUERY   = 3'd4,
    K_UNKNOWN = 3'd5,
    K_OOR     = 3'd6
  } kind_t;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    kind_t              kind;
    logic [CHAN_W-1:0]  channel;
    logic               eligible;
    logic               network_up;
    logic [RND_W-1:0]   rnd;
  } cmd_t;

  // Command queue between front and back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Network-up delay: one plus the bit pair taken modulo three.
  function automatic logic [1:0] net_delay(input logic [1:0] pick);
    logic [1:0] d;
    unique case (pick)
      2'd0:    d = 2'd1;
      2'd1:    d = 2'd2;
      2'd2:    d = 2'd3;
      default: d = 2'd1;
    endcase
    return d;
  endfunction

endpackage

### rtl/rbs_if.sv
// Handshake interfaces for the item and result channels of the scheduler.
interface rbs_in_if;
  import rbs_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [CHAN_W-1:0]   channel;
  logic                is_fatal;
  logic                eligible;
  logic                network_up;
  logic [RND_W-1:0]    random_word;

  modport source (output valid, opcode, channel, is_fatal, eligible, network_up,
                  random_word, input ready);
  modport sink   (input valid, opcode, channel, is_fatal, eligible, network_up,
                  random_word, output ready);
endinterface

interface rbs_out_if;
  import rbs_pkg::*;

  logic                valid;
  logic                ready;
  logic [CHAN_W-1:0]   out_channel;
  logic [ACTION_W-1:0] action;
  logic [DELAY_W-1:0]  delay_seconds;
  logic [ATT_W-1:0]    attempt_count;
  logic                last;

  modport source (output valid, out_channel, action, delay_seconds, attempt_count,
                  last, input ready);
  modport sink   (input valid, out_channel, action, delay_seconds, attempt_count,
                  last, output ready);
endinterface

### rtl/rbs_front.sv
// Front end: accepts input items, classifies them and registers the command.
module rbs_front (
  input  logic          clk,
  input  logic          rst_n,
  rbs_in_if.sink        in_ch,
  output rbs_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i
);
  import rbs_pkg::*;

  logic  stage_v_r, stage_v_nxt;
  cmd_t  stage_r;
  cmd_t  cls;
  logic  oor;

  // The stage takes a new item when empty or when its command moves on.
  assign in_ch.ready = !stage_v_r || cmd_ready_i;
  assign cmd_o       = stage_r;
  assign cmd_valid_o = stage_v_r;

  // Classify the item; network up ignores the channel field.
  always_comb begin
    oor            = (in_ch.opcode != OP_NETUP) && ({1'b0, in_ch.channel} >= CHAN_LIMIT);
    cls.channel    = in_ch.channel;
    cls.eligible   = in_ch.eligible;
    cls.network_up = in_ch.network_up;
    cls.rnd        = in_ch.random_word;
    if (oor) begin
      cls.kind = K_OOR;
    end else begin
      unique case (in_ch.opcode)
        OP_FAIL:   cls.kind = in_ch.is_fatal ? K_RESET : K_FAIL;
        OP_CANCEL: cls.kind = K_RESET;
        OP_EXPIRE: cls.kind = K_EXPIRE;
        OP_NETUP:  cls.kind = K_NETUP;
        OP_QUERY:  cls.kind = K_QUERY;
        default:   cls.kind = K_UNKNOWN;
      endcase
    end
  end

  // Stage occupancy.
  always_comb begin
    stage_v_nxt = stage_v_r;
    if (in_ch.valid && in_ch.ready) begin
      stage_v_nxt = 1'b1;
    end else if (cmd_ready_i) begin
      stage_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  // Command payload is loaded on each input transfer.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stage_r <= cls;
    end
  end

endmodule

### rtl/rbs_queue.sv
// Short command queue that decouples the front end from the back end.
module rbs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  rbs_pkg::cmd_t push_data_i,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  output rbs_pkg::cmd_t pop_data_o,
  output logic          pop_valid_o,
  input  logic          pop_ready_i
);
  import rbs_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign push_ready_o = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_r != '0);
  assign pop_data_o   = slot_r[rd_ptr_r];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data_i;
    end
  end

endmodule

### rtl/rbs_back.sv
// Back end: channel records, backoff arithmetic, network-up walk and result register.
module rbs_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rbs_pkg::CFG_W-1:0]       cfg_wdata,
  input  rbs_pkg::cmd_t                   cmd_i,
  input  logic                            cmd_valid_i,
  output logic                            cmd_ready_o,
  rbs_out_if.source                       out_ch
);
  import rbs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_BASE = 5'b00010,
    S_MUL  = 5'b00100,
    S_EMIT = 5'b01000,
    S_WALK = 5'b10000
  } state_t;

  state_t              state_r;
  cmd_t                cmd_r;

  // Configuration registers.
  logic                en_r;
  logic [CFG_W-1:0]    ini_r, max_r, max_att_r;

  // Channel records.
  logic [ATT_W-1:0]    att_tab_r [CHANNELS];
  logic [DELAY_W-1:0]  dly_tab_r [CHANNELS];
  logic [CHANNELS-1:0] pend_r, park_r;

  // Backoff pipeline registers.
  logic [ATT_W-1:0]    att_new_r;
  logic                gave_up_r;
  logic [BASE_W-1:0]   base_r;
  logic [PROD_W-1:0]   prod_r;
  logic [CH_IDX_W-1:0] walk_r;

  // Result register.
  logic                out_valid_r;
  logic [CHAN_W-1:0]   out_ch_r;
  action_t             out_act_r;
  logic [DELAY_W-1:0]  out_dly_r;
  logic [ATT_W-1:0]    out_att_r;
  logic                out_last_r;

  logic [CH_IDX_W-1:0] ch_idx;
  logic [ATT_W-1:0]    att_cur;
  logic                pend_cur;
  logic                go_ok;
  logic [BASE_W-1:0]   ini_eff, cap;
  logic [ATT_W-1:0]    att_inc, att_m1;
  logic [SHIFT_W-1:0]  sh;
  logic [SHL_W-1:0]    shifted;
  logic [BASE_W-1:0]   base_nxt;
  logic                gave_nxt;
  logic [SPAN_W-1:0]   span;
  logic [DELAY_W-1:0]  sched_d;
  logic                out_free;
  logic                out_load;
  logic                park_above;
  logic [1:0]          walk_d;
  action_t             res_act;
  logic [DELAY_W-1:0]  res_dly;
  logic [ATT_W-1:0]    res_att;

  assign cmd_ready_o = (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;

  // A result is loaded whenever the sequencer emits one this cycle.
  assign out_load = out_free &&
                    ((state_r == S_EMIT) || ((state_r == S_WALK) && park_r[walk_r]));

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_channel   = out_ch_r;
  assign out_ch.action        = out_act_r;
  assign out_ch.delay_seconds = out_dly_r;
  assign out_ch.attempt_count = out_att_r;
  assign out_ch.last          = out_last_r;

  // Record read for the current command.
  assign ch_idx   = cmd_r.channel[CH_IDX_W-1:0];
  assign att_cur  = att_tab_r[ch_idx];
  assign pend_cur = pend_r[ch_idx];
  assign go_ok    = en_r && cmd_r.eligible;

  // Base delay: initial shifted by attempts less one (capped), clamped to the cap.
  always_comb begin
    ini_eff  = (ini_r == '0) ? BASE_W'(1) : ini_r;
    cap      = (max_r < ini_eff) ? ini_eff : max_r;
    att_inc  = (att_cur == ATT_MAX) ? att_cur : att_cur + 1'b1;
    att_m1   = att_inc - 1'b1;
    sh       = (att_m1 > ATT_W'(SHIFT_CAP)) ? SHIFT_W'(SHIFT_CAP) : att_m1[SHIFT_W-1:0];
    shifted  = SHL_W'(ini_eff) << sh;
    base_nxt = (shifted > SHL_W'(cap)) ? cap : shifted[BASE_W-1:0];
    gave_nxt = (max_att_r != '0) && (att_inc > max_att_r);
  end

  // Jitter span and final scheduled delay.
  assign span    = SPAN_W'(base_r / JITTER_DIV) + SPAN_W'(1);
  assign sched_d = DELAY_W'(base_r) + DELAY_W'(prod_r[PROD_W-1:RND_LO_W]);

  // Network-up walk: delay pick and whether any parked channel lies beyond.
  assign walk_d = net_delay(cmd_r.rnd[2*walk_r +: 2]);

  always_comb begin
    park_above = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (park_r[c] && (CH_IDX_W'(c) > walk_r)) begin
        park_above = 1'b1;
      end
    end
  end

  // Single result for every command other than a network-up walk.
  always_comb begin
    res_act = ACT_IGNORED;
    res_dly = '0;
    res_att = att_cur;
    unique case (cmd_r.kind)
      K_FAIL: begin
        if (!go_ok) begin
          res_act = ACT_IGNORED;
        end else if (gave_up_r) begin
          res_act = ACT_GAVE_UP;
          res_att = att_new_r;
        end else begin
          res_act = ACT_SCHEDULED;
          res_dly = sched_d;
          res_att = att_new_r;
        end
      end
      K_RESET: begin
        res_act = ACT_RESET;
        res_att = '0;
      end
      K_EXPIRE: begin
        priority if (!pend_cur) begin
          res_act = ACT_IGNORED;
        end else if (!go_ok) begin
          res_act = ACT_DROPPED;
        end else if (!cmd_r.network_up) begin
          res_act = ACT_PARKED;
        end else begin
          res_act = ACT_CONNECT;
        end
      end
      K_QUERY: begin
        res_act = ACT_QUERY;
        res_dly = pend_cur ? dly_tab_r[ch_idx] : '0;
      end
      K_NETUP: begin
        res_act = ACT_NONE;
        res_att = '0;
      end
      K_OOR: begin
        res_act = ACT_IGNORED;
        res_att = '0;
      end
      default: begin
        res_act = ACT_IGNORED;
      end
    endcase
  end

  // Sequencer, record updates and configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      en_r        <= 1'b1;
      ini_r       <= RESET_INITIAL;
      max_r       <= RESET_MAX;
      max_att_r   <= '0;
      pend_r      <= '0;
      park_r      <= '0;
      walk_r      <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        att_tab_r[c] <= '0;
      end
    end else begin
      if (out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_r <= cmd_i;
            priority if (cmd_i.kind == K_NETUP && (|park_r)) begin
              walk_r  <= '0;
              state_r <= S_WALK;
            end else if (cmd_i.kind == K_FAIL && en_r && cmd_i.eligible) begin
              state_r <= S_BASE;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_BASE: begin
          att_new_r <= att_inc;
          gave_up_r <= gave_nxt;
          base_r    <= base_nxt;
          state_r   <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= PROD_W'(cmd_r.rnd[RND_LO_W-1:0]) * PROD_W'(span);
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_ch_r    <= (cmd_r.kind == K_NETUP) ? '0 : cmd_r.channel;
            out_act_r   <= res_act;
            out_dly_r   <= res_dly;
            out_att_r   <= res_att;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
            // Record updates for the command just answered.
            if (cmd_r.kind == K_FAIL && go_ok) begin
              att_tab_r[ch_idx] <= att_new_r;
              park_r[ch_idx]    <= 1'b0;
              pend_r[ch_idx]    <= !gave_up_r;
              dly_tab_r[ch_idx] <= sched_d;
            end else if (cmd_r.kind == K_RESET) begin
              att_tab_r[ch_idx] <= '0;
              pend_r[ch_idx]    <= 1'b0;
              park_r[ch_idx]    <= 1'b0;
            end else if (cmd_r.kind == K_EXPIRE && pend_cur) begin
              pend_r[ch_idx] <= 1'b0;
              park_r[ch_idx] <= go_ok && !cmd_r.network_up;
            end
          end
        end
        S_WALK: begin
          if (park_r[walk_r]) begin
            if (out_free) begin
              out_valid_r       <= 1'b1;
              out_ch_r          <= CHAN_W'(walk_r);
              out_act_r         <= ACT_SCHEDULED;
              out_dly_r         <= DELAY_W'(walk_d);
              out_att_r         <= att_tab_r[walk_r];
              out_last_r        <= !park_above;
              park_r[walk_r]    <= 1'b0;
              pend_r[walk_r]    <= 1'b1;
              dly_tab_r[walk_r] <= DELAY_W'(walk_d);
              if (park_above) begin
                walk_r <= walk_r + 1'b1;
              end else begin
                state_r <= S_IDLE;
              end
            end
          end else begin
            walk_r <= walk_r + 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      // Configuration writes must arrive only while idle: the user's duty, unchecked.
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENABLE: begin
            en_r <= cfg_wdata[0];
            if (!cfg_wdata[0]) begin
              pend_r <= '0;
              park_r <= '0;
            end
          end
          REG_INITIAL:  ini_r     <= cfg_wdata;
          REG_MAX:      max_r     <= cfg_wdata;
          REG_ATTEMPTS: max_att_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // A channel is never pending and parked at once.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) (pend_r & park_r) == '0)
    else $error("channel both pending and parked");

  // The network-up walk only runs while a parked channel remains.
  a_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (|park_r))
    else $error("walk running with no parked channel");

  // A scheduled retry is never zero seconds out.
  a_sched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_act_r == ACT_SCHEDULED) |-> (out_dly_r != '0))
    else $error("scheduled result with zero delay");

  // Disabling retries cancels every pending and parked channel.
  a_disable: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == REG_ENABLE && !cfg_wdata[0]) |=> (pend_r == '0 && park_r == '0))
    else $error("flags left set after disable");

endmodule

### rtl/retry_backoff_scheduler.sv
// Top level of the retry backoff scheduler: front end, command queue and back end.
//
// Usage: events enter on in_ch (valid/ready); a transfer takes one event with an
// opcode, a channel and random bits. Results leave on out_ch (valid/ready); the
// last result caused by an event carries last. Registers are written through the
// plain cfg_we/cfg_index/cfg_wdata port while no event is in flight.
// Path: a failure that schedules a retry passes the front stage, queue, command
// register, base delay, jitter multiply and result register; other single-result
// events skip the base delay and jitter multiply.
// Sequencing: the back end handles one event at a time. Network up walks the
// channel records one per cycle while no result waits on a stalled receiver,
// giving one result per parked channel.
// Reset (rst_n low at a clock edge) clears channel flags and attempt counts and
// restores the registers to enabled, initial 8, max 480 and no attempt limit.
// When the receiver stalls, the result register holds; the queue and front stage
// keep taking events until they fill, then in_ch.ready drops.
module retry_backoff_scheduler (
  input  logic                          clk,
  input  logic                          rst_n,
  rbs_in_if.sink                        in_ch,
  rbs_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [rbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbs_pkg::CFG_W-1:0]     cfg_wdata
);
  import rbs_pkg::*;

  cmd_t front_cmd, queue_cmd;
  logic front_valid, front_ready;
  logic queue_valid, queue_ready;

  // Accept and classify events.
  rbs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  // Buffer classified commands.
  rbs_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_data_i  (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (queue_cmd),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready)
  );

  // Execute commands against the channel records.
  rbs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .cmd_i       (queue_cmd),
    .cmd_valid_i (queue_valid),
    .cmd_ready_o (queue_ready),
    .out_ch      (out_ch)
  );

endmodule

### tb/tb.sv
// Self-checking testbench for the retry backoff scheduler, with its own predictor of every result.
module tb;
  import rbs_pkg::*;

  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int NET_SPREAD    = 3;
  localparam int LIMIT_CHANNEL = 9;

  // Opcodes that the block does not define.
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [CHAN_W-1:0]   channel;
    logic                is_fatal;
    logic                eligible;
    logic                network_up;
    logic [RND_W-1:0]    random_word;
  } event_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  channel;
    action_t            action;
    logic [DELAY_W-1:0] delay;
    logic [ATT_W-1:0]   tries;
    logic               last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  rbs_in_if  in_ch ();
  rbs_out_if out_ch ();

  retry_backoff_scheduler uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the register file.
  logic             reg_enable  = 1'b1;
  logic [CFG_W-1:0] reg_initial = RESET_INITIAL;
  logic [CFG_W-1:0] reg_max     = RESET_MAX;
  logic [CFG_W-1:0] reg_limit   = '0;

  // Mirror of the channel records.
  logic [ATT_W-1:0]   tries     [CHANNELS];
  logic [DELAY_W-1:0] wait_secs [CHANNELS];
  logic               armed     [CHANNELS];
  logic               parked    [CHANNELS];

  result_t due_results[$];
  int      failures     = 0;
  int      cycle_count  = 0;
  int      hold_off     = 0;
  bit      sender_quiet   = 1'b0;
  bit      receiver_quiet = 1'b0;

  initial begin
    for (int c = 0; c < CHANNELS; c++) begin
      tries[c]     = '0;
      wait_secs[c] = '0;
      armed[c]     = 1'b0;
      parked[c]    = 1'b0;
    end
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length: mostly none, often short, now and then a long one.
  function automatic int idle_span(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void release_slot(input int c);
    armed[c]     = 1'b0;
    parked[c]    = 1'b0;
    wait_secs[c] = '0;
  endfunction

  function automatic void queue_result(input logic [CHAN_W-1:0] ch, input action_t act,
                                       input logic [DELAY_W-1:0] secs,
                                       input logic [ATT_W-1:0] cnt, input logic fin);
    result_t r;
    r.channel = ch;
    r.action  = act;
    r.delay   = secs;
    r.tries   = cnt;
    r.last    = fin;
    due_results.push_back(r);
  endfunction

  // Capped exponential base delay plus a jitter scaled by the low random bits.
  function automatic logic [DELAY_W-1:0] backoff_delay(input logic [ATT_W-1:0] count,
                                                       input logic [RND_LO_W-1:0] spread);
    logic [SHL_W-1:0] start;
    logic [SHL_W-1:0] ceiling;
    logic [SHL_W-1:0] base;
    logic [31:0]      scaled;
    int               shift;
    start   = (reg_initial == '0) ? SHL_W'(1) : SHL_W'(reg_initial);
    ceiling = (SHL_W'(reg_max) < start) ? start : SHL_W'(reg_max);
    shift   = (count > 0) ? int'(count) - 1 : 0;
    if (shift > SHIFT_CAP) shift = SHIFT_CAP;
    base = start << shift;
    if (base > ceiling) base = ceiling;
    scaled = 32'(spread) * (32'(base) / JITTER_DIV + 32'd1);
    return DELAY_W'(base) + DELAY_W'(scaled >> 16);
  endfunction

  // Update the channel records for one accepted transfer and queue its results.
  function automatic void apply_retry_event(input event_t e);
    int                 ch;
    int                 waiting;
    int                 seen;
    logic [DELAY_W-1:0] secs;
    ch = int'(e.channel);
    if (e.opcode == OP_NETUP) begin
      waiting = 0;
      seen    = 0;
      for (int c = 0; c < CHANNELS; c++) if (parked[c]) waiting++;
      if (waiting == 0) queue_result('0, ACT_NONE, '0, '0, 1'b1);
      for (int c = 0; c < CHANNELS; c++) begin
        if (parked[c]) begin
          secs = DELAY_W'(1 + e.random_word[2*c +: 2] % NET_SPREAD);
          parked[c]    = 1'b0;
          armed[c]     = 1'b1;
          wait_secs[c] = secs;
          seen++;
          queue_result(CHAN_W'(c), ACT_SCHEDULED, secs, tries[c], seen == waiting);
        end
      end
    end else if (ch >= CHANNELS) begin
      queue_result(e.channel, ACT_IGNORED, '0, '0, 1'b1);
    end else begin
      case (e.opcode)
        OP_FAIL: begin
          if (e.is_fatal) begin
            release_slot(ch);
            tries[ch] = '0;
            queue_result(e.channel, ACT_RESET, '0, '0, 1'b1);
          end else if (!reg_enable || !e.eligible) begin
            queue_result(e.channel, ACT_IGNORED, '0, tries[ch], 1'b1);
          end else begin
            release_slot(ch);
            if (tries[ch] != ATT_MAX) tries[ch] = tries[ch] + 1'b1;
            if (reg_limit != '0 && tries[ch] > reg_limit) begin
              queue_result(e.channel, ACT_GAVE_UP, '0, tries[ch], 1'b1);
            end else begin
              secs = backoff_delay(tries[ch], e.random_word[RND_LO_W-1:0]);
              wait_secs[ch] = secs;
              armed[ch]     = 1'b1;
              queue_result(e.channel, ACT_SCHEDULED, secs, tries[ch], 1'b1);
            end
          end
        end
        OP_CANCEL: begin
          release_slot(ch);
          tries[ch] = '0;
          queue_result(e.channel, ACT_RESET, '0, '0, 1'b1);
        end
        OP_EXPIRE: begin
          if (!armed[ch]) begin
            queue_result(e.channel, ACT_IGNORED, '0, tries[ch], 1'b1);
          end else if (!reg_enable || !e.eligible) begin
            release_slot(ch);
            queue_result(e.channel, ACT_DROPPED, '0, tries[ch], 1'b1);
          end else if (!e.network_up) begin
            armed[ch]     = 1'b0;
            parked[ch]    = 1'b1;
            wait_secs[ch] = '0;
            queue_result(e.channel, ACT_PARKED, '0, tries[ch], 1'b1);
          end else begin
            armed[ch]     = 1'b0;
            wait_secs[ch] = '0;
            queue_result(e.channel, ACT_CONNECT, '0, tries[ch], 1'b1);
          end
        end
        OP_QUERY: begin
          queue_result(e.channel, ACT_QUERY, armed[ch] ? wait_secs[ch] : '0, tries[ch], 1'b1);
        end
        default: begin
          queue_result(e.channel, ACT_IGNORED, '0, tries[ch], 1'b1);
        end
      endcase
    end
  endfunction

  function automatic event_t make_event(input logic [OPCODE_W-1:0] op, input int ch,
                                        input bit fatal, input bit elig, input bit net,
                                        input logic [RND_W-1:0] rnd);
    event_t e;
    e.opcode      = op;
    e.channel     = CHAN_W'(ch);
    e.is_fatal    = fatal;
    e.eligible    = elig;
    e.network_up  = net;
    e.random_word = rnd;
    return e;
  endfunction

  // Mostly failures followed by expiries of pending channels, with some noise mixed in.
  function automatic event_t random_event();
    event_t e;
    int     r;
    int     first;
    int     idx;
    bit     found;
    e.random_word = $urandom();
    e.channel     = $urandom_range(0, 1) ? CHAN_W'($urandom_range(0, 3))
                                         : CHAN_W'($urandom_range(0, CHANNELS - 1));
    e.is_fatal    = ($urandom_range(0, 9) == 0);
    e.eligible    = ($urandom_range(0, 7) != 0);
    e.network_up  = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 35) begin
      e.opcode = OP_FAIL;
    end else if (r < 60) begin
      e.opcode = OP_EXPIRE;
      if ($urandom_range(0, 3) != 0) begin
        first = $urandom_range(0, CHANNELS - 1);
        found = 1'b0;
        for (int k = 0; k < CHANNELS; k++) begin
          idx = (first + k) % CHANNELS;
          if (!found && armed[idx]) begin
            e.channel = CHAN_W'(idx);
            found = 1'b1;
          end
        end
      end
    end else if (r < 68) begin
      e.opcode = OP_CANCEL;
    end else if (r < 78) begin
      e.opcode = OP_NETUP;
    end else if (r < 94) begin
      e.opcode = OP_QUERY;
    end else begin
      e.opcode = OPCODE_W'($urandom_range(int'(OP_SPARE_LO), int'(OP_SPARE_HI)));
    end
    return e;
  endfunction

  // Offer one item and wait for its transfer; valid stays high for a back-to-back item.
  task automatic send_event(input event_t e);
    int gap;
    gap = idle_span(sender_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= e.opcode;
    in_ch.channel     <= e.channel;
    in_ch.is_fatal    <= e.is_fatal;
    in_ch.eligible    <= e.eligible;
    in_ch.network_up  <= e.network_up;
    in_ch.random_word <= e.random_word;
    do @(posedge clk); while (!in_ch.ready);
    apply_retry_event(e);
  endtask

  // Stop offering items and wait until every result has come back.
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_ENABLE: begin
        reg_enable = value[0];
        if (!reg_enable) for (int c = 0; c < CHANNELS; c++) release_slot(c);
      end
      REG_INITIAL:  reg_initial = value;
      REG_MAX:      reg_max     = value;
      REG_ATTEMPTS: reg_limit   = value;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all_regs(input logic en, input logic [CFG_W-1:0] ini,
                                input logic [CFG_W-1:0] cap, input logic [CFG_W-1:0] lim);
    write_reg(REG_ENABLE, CFG_W'(en));
    write_reg(REG_INITIAL, ini);
    write_reg(REG_MAX, cap);
    write_reg(REG_ATTEMPTS, lim);
  endtask

  // Every opcode and special case at the reset register values.
  task automatic test_directed_cases();
    send_event(make_event(OP_QUERY, 0, 0, 1, 1, 32'h0000_0000));
    send_event(make_event(OP_FAIL, 3, 0, 1, 1, 32'h0000_0000));
    send_event(make_event(OP_FAIL, 3, 0, 1, 1, 32'h0000_FFFF));
    send_event(make_event(OP_QUERY, 3, 0, 1, 1, 32'hFFFF_FFFF));
    send_event(make_event(OP_EXPIRE, 3, 0, 1, 1, 32'h0000_0000));
    // Expiry with nothing pending is ignored.
    send_event(make_event(OP_EXPIRE, 3, 0, 1, 1, 32'h0000_0000));
    send_event(make_event(OP_FAIL, 5, 0, 0, 1, 32'h0000_0000));
    send_event(make_event(OP_FAIL, 5, 0, 1, 1, 32'h0000_8000));
    send_event(make_event(OP_EXPIRE, 5, 0, 1, 0, 32'h0000_0000));
    send_event(make_event(OP_FAIL, 6, 0, 1, 0, 32'h1234_5678));
    send_event(make_event(OP_EXPIRE, 6, 0, 0, 1, 32'h0000_0000));
    send_event(make_event(OP_FAIL, 15, 0, 1, 0, 32'hFFFF_0000));
    send_event(make_event(OP_EXPIRE, 15, 0, 1, 0, 32'h0000_0000));
    send_event(make_event(OP_FAIL, 0, 0, 1, 1, 32'h0000_4000));
    send_event(make_event(OP_EXPIRE, 0, 0, 1, 0, 32'h0000_0000));
    // Three parked channels get bit pairs of 0, 2 and 3.
    send_event(make_event(OP_NETUP, 7, 1, 0, 0, 32'hC000_0800));
    // Network up with nothing parked.
    send_event(make_event(OP_NETUP, 15, 0, 1, 1, 32'hFFFF_FFFF));
    send_event(make_event(OP_QUERY, 5, 0, 1, 1, 32'h0000_0000));
    send_event(make_event(OP_FAIL, 5, 1, 1, 1, 32'h0000_0000));
    send_event(make_event(OP_CANCEL, 15, 0, 0, 0, 32'h0000_0000));
    send_event(make_event(OP_SPARE_LO, 0, 0, 1, 1, 32'h0000_0000));
    send_event(make_event(OP_SPARE_MID, 15, 1, 1, 1, 32'hFFFF_FFFF));
    send_event(make_event(OP_SPARE_HI, 3, 0, 0, 0, 32'h0000_0000));
    send_event(make_event(OP_FAIL, 10, 0, 1, 1, 32'hFFFF_FFFF));
    send_event(make_event(OP_QUERY, 10, 0, 1, 1, 32'h0000_0000));
    settle_block();
  endtask

  // Random traffic under a series of register settings, the extremes among them.
  task automatic test_config_sweep();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_all_regs(1'b1, 16'd1, 16'hFFFF, 16'd0);
        1: write_all_regs(1'b1, 16'hFFFF, 16'd1, 16'd3);
        2: write_all_regs(1'b1, 16'd0, 16'd0, 16'hFFFF);
        // Disabling cancels every pending and parked channel.
        3: write_reg(REG_ENABLE, CFG_W'(0));
        4: write_all_regs(1'b1, CFG_W'($urandom_range(1, 40)), CFG_W'($urandom_range(1, 2000)),
                          CFG_W'($urandom_range(1, 6)));
        default: write_all_regs(1'b1, RESET_INITIAL, RESET_MAX, 16'd0);
      endcase
      repeat (15) send_event(random_event());
      settle_block();
    end
  endtask

  // The receiver holds off while items keep coming, then the sender waits for every result.
  task automatic test_backpressure();
    sender_quiet = 1'b1;
    hold_off = 300;
    repeat (20) send_event(random_event());
    sender_quiet = 1'b0;
    settle_block();
    repeat (10) send_event(random_event());
    settle_block();
  endtask

  // Drive one channel past the attempt limit, then clear its record.
  task automatic test_attempt_limit();
    event_t e;
    write_all_regs(1'b1, 16'd1, 16'd1, 16'd3);
    sender_quiet   = 1'b1;
    receiver_quiet = 1'b1;
    e = make_event(OP_FAIL, LIMIT_CHANNEL, 0, 1, 1, 32'h0);
    repeat (5) begin
      e.random_word = $urandom();
      send_event(e);
    end
    send_event(make_event(OP_QUERY, LIMIT_CHANNEL, 0, 1, 1, 32'h0));
    send_event(make_event(OP_CANCEL, LIMIT_CHANNEL, 0, 1, 1, 32'h0));
    send_event(make_event(OP_QUERY, LIMIT_CHANNEL, 0, 1, 1, 32'h0));
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    settle_block();
  endtask

  // Result side: random stalls, plus a requested hold-off counted down here.
  initial begin : result_receiver
    int   stall;
    logic rdy;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold_off = hold_off - 1;
        rdy = 1'b0;
      end else if (stall > 0) begin
        stall = stall - 1;
        rdy = 1'b0;
      end else if (!receiver_quiet && $urandom_range(0, 3) == 0) begin
        stall = idle_span(1'b0);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ch.ready <= rdy;
    end
  end

  // Compare each result transfer with the oldest expected result.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: out_channel %0d action %0d", out_ch.out_channel,
               out_ch.action);
        failures++;
      end else begin
        want = due_results.pop_front();
        if (out_ch.out_channel !== want.channel) begin
          $error("out_channel: expected %0d, got %0d", want.channel, out_ch.out_channel);
          failures++;
        end
        if (out_ch.action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, out_ch.action);
          failures++;
        end
        if (out_ch.delay_seconds !== want.delay) begin
          $error("delay_seconds: expected %0d, got %0d", want.delay, out_ch.delay_seconds);
          failures++;
        end
        if (out_ch.attempt_count !== want.tries) begin
          $error("attempt_count: expected %0d, got %0d", want.tries, out_ch.attempt_count);
          failures++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          failures++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.opcode      <= OP_FAIL;
    in_ch.channel     <= '0;
    in_ch.is_fatal    <= 1'b0;
    in_ch.eligible    <= 1'b0;
    in_ch.network_up  <= 1'b0;
    in_ch.random_word <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_ENABLE;
    cfg_wdata         <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_config_sweep();
    test_backpressure();
    test_attempt_limit();

    settle_block();
    if (failures == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/rbs_pkg.sv
rtl/rbs_if.sv
rtl/rbs_front.sv
rtl/rbs_queue.sv
rtl/rbs_back.sv
rtl/retry_backoff_scheduler.sv
tb/tb.sv
